// ===== hw/rtl/asa_pkg.sv =====
// asa_pkg: shared constants and types of the ASID slot allocator.
// Opcodes, field widths, result layout and parameter defaults. No dependencies.
package asa_pkg;

  localparam int ASA_SLOT_COUNT = 256;
  localparam int ASA_OWNER_BITS = 16;

  localparam int SLOT_FW  = 8;
  localparam int ASID_FW  = 8;
  localparam int OWNER_FW = 16;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_REBIND = 2'd2;
  localparam logic [1:0] OP_LOOKUP = 2'd3;

  // bit positions in out_tdata
  localparam int OUT_INV_BIT = 16;
  localparam int OUT_EVV_BIT = 17;
  localparam int OUT_MVV_BIT = 34;

  typedef struct packed {
    logic                status;
    logic [SLOT_FW-1:0]  slot;
    logic [ASID_FW-1:0]  asid;
    logic                invalidate;
    logic                evicted_valid;
    logic [OWNER_FW-1:0] evicted_owner;
    logic                moved_valid;
    logic [OWNER_FW-1:0] moved_owner;
    logic [SLOT_FW-1:0]  moved_slot;
  } asa_res_t;

endpackage

// ===== hw/rtl/asa_asid_ram.sv =====
// asa_asid_ram: slot-to-ASID table, two registered read ports, one write port.
// Per-entry valid bits; an unwritten entry reads as its own slot number. Uses asa_pkg.
module asa_asid_ram #(
  parameter int SLOT_COUNT = asa_pkg::ASA_SLOT_COUNT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(SLOT_COUNT)-1:0] ra_addr,
  input  logic [$clog2(SLOT_COUNT)-1:0] rb_addr,
  input  logic                          we,
  input  logic [$clog2(SLOT_COUNT)-1:0] wa,
  input  logic [asa_pkg::ASID_FW-1:0]   wd,
  output logic [asa_pkg::ASID_FW-1:0]   ra_data,
  output logic [asa_pkg::ASID_FW-1:0]   rb_data
);
  import asa_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);

  logic [ASID_FW-1:0]    mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_r;
  logic [ASID_FW-1:0]    qa_r, qb_r;
  logic                  va_r, vb_r;
  logic [SW-1:0]         aa_r, ab_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    qa_r <= mem[ra_addr];
    qb_r <= mem[rb_addr];
    aa_r <= ra_addr;
    ab_r <= rb_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
    end else begin
      if (we) begin
        vld_r[wa] <= 1'b1;
      end
      va_r <= vld_r[ra_addr];
      vb_r <= vld_r[rb_addr];
    end
  end

  assign ra_data = va_r ? qa_r : ASID_FW'(aa_r);
  assign rb_data = vb_r ? qb_r : ASID_FW'(ab_r);

endmodule

// ===== hw/rtl/asa_owner_ram.sv =====
// asa_owner_ram: owner handle per slot, one write port, one registered read port.
// Contents undefined until written. Uses asa_pkg for defaults.
module asa_owner_ram #(
  parameter int SLOT_COUNT = asa_pkg::ASA_SLOT_COUNT,
  parameter int OWNER_BITS = asa_pkg::ASA_OWNER_BITS
) (
  input  logic                          clk,
  input  logic [$clog2(SLOT_COUNT)-1:0] ra,
  input  logic                          we,
  input  logic [$clog2(SLOT_COUNT)-1:0] wa,
  input  logic [OWNER_BITS-1:0]         wd,
  output logic [OWNER_BITS-1:0]         rd
);
  import asa_pkg::*;

  logic [OWNER_BITS-1:0] mem [SLOT_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd <= mem[ra];
  end

endmodule

// ===== hw/rtl/asid_slot_allocator.sv =====
// asid_slot_allocator: top level, request sequencer, occupancy bits, pointer, output register.
// Instantiates asa_asid_ram and asa_owner_ram; uses asa_pkg.
//
// Usage:
//   in_* : one request per beat. in_tuser = opcode (alloc, free, rebind, lookup);
//          in_tdata = owner_id, owner_slot, current_asid.
//   out_*: one result beat per request. out_tuser = status; out_tdata = slot, asid,
//          invalidate, evicted valid/owner, moved valid/owner/slot.
//   in_tready is high only while the sequencer is idle; one request at a time. It
//   returns in the cycle out_tvalid rises.
// Sequence (accept to out_tvalid):
//   rebind, rejected free/lookup: dispatch, output; lookup: dispatch, ASID read, output;
//   free: dispatch, then output (top slot) or FWR1, FWR2 swap writes, output; alloc: a
//   step and check per nonzero slot, a step alone at slot 0, then read, take, output;
//   the probe walks occupancy bits and ASID table slot by slot, up to SLOT_COUNT steps.
// Reset: occupancy and ASID valid bits clear at once (ASIDs read as identity),
//   pointer goes to 0; the owner table is not cleared.
// Stall: a result waits in the output register; a finished request after it
//   holds in the sequencer until that register drains, then in_tready returns.
module asid_slot_allocator #(
  parameter int SLOT_COUNT = asa_pkg::ASA_SLOT_COUNT,
  parameter int OWNER_BITS = asa_pkg::ASA_OWNER_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // owner_id[15:0], owner_slot[23:16], current_asid[31:24]
  input  logic [1:0]  in_tuser,   // opcode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // slot[7:0], asid[15:8], invalidate[16], evicted_valid[17],
                                  // evicted_owner[33:18], moved_valid[34], moved_owner[50:35],
                                  // moved_slot[58:51], zero[63:59]
  output logic        out_tuser   // status[0]
);
  import asa_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int NW = $clog2(SLOT_COUNT + 1);
  localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DISP   = 4'd1;
  localparam logic [3:0] S_PSTEP  = 4'd2;
  localparam logic [3:0] S_PCHK   = 4'd3;
  localparam logic [3:0] S_TAKERD = 4'd4;
  localparam logic [3:0] S_TAKE   = 4'd5;
  localparam logic [3:0] S_FWR1   = 4'd6;
  localparam logic [3:0] S_FWR2   = 4'd7;
  localparam logic [3:0] S_LKUP   = 4'd8;
  localparam logic [3:0] S_OUT    = 4'd9;

  logic [3:0]            state_r, state_nxt;
  logic [1:0]            op_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic [SLOT_FW-1:0]    oslot_r;
  logic [ASID_FW-1:0]    cur_r;
  logic [SW-1:0]         top_r, top_nxt;
  logic [SW-1:0]         p_r, p_nxt;
  logic [NW-1:0]         n_r, n_nxt;
  logic [ASID_FW-1:0]    swap_r, swap_nxt;
  logic [SLOT_COUNT-1:0] occ_r;
  asa_res_t              res_r, res_nxt;
  asa_res_t              out_r;
  logic                  out_valid_r;

  logic                  occ_we, occ_wd;
  logic [SW-1:0]         occ_wa;
  logic [SW-1:0]         asid_ra, asid_rb, asid_wa;
  logic                  asid_we;
  logic [ASID_FW-1:0]    asid_wd, asid_a, asid_b;
  logic [SW-1:0]         own_ra, own_wa;
  logic                  own_we;
  logic [OWNER_BITS-1:0] own_wd, own_rd;

  logic [SW-1:0]         oslot_idx, pn, pf, top_low;
  logic                  slot_ok, slot_in_range, found;
  logic [31:0]           owner_ext, own_rd_ext;

  assign oslot_idx     = oslot_r[SW-1:0];
  assign slot_in_range = {1'b0, oslot_r} < 9'(SLOT_COUNT);
  assign slot_ok       = (oslot_r != '0) && slot_in_range;
  assign pn            = (p_r == LAST) ? '0 : p_r + 1'b1;
  assign pf            = (p_r == '0) ? SW'(1) : p_r;
  assign top_low       = (top_r <= SW'(1)) ? LAST : top_r - 1'b1;
  assign found         = !occ_r[p_r] || (asid_a != cur_r);
  assign own_rd_ext    = 32'(own_rd);
  assign owner_ext     = 32'(in_tdata[15:0]);

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    top_nxt   = top_r;
    p_nxt     = p_r;
    n_nxt     = n_r;
    swap_nxt  = swap_r;
    res_nxt   = res_r;
    occ_we    = 1'b0;
    occ_wa    = oslot_idx;
    occ_wd    = 1'b0;
    asid_ra   = oslot_idx;
    asid_rb   = top_r;
    asid_we   = 1'b0;
    asid_wa   = oslot_idx;
    asid_wd   = asid_b;
    own_ra    = top_r;
    own_we    = 1'b0;
    own_wa    = oslot_idx;
    own_wd    = owner_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        res_nxt = '0;
        case (op_r)
          OP_ALLOC: begin
            p_nxt     = top_r;
            n_nxt     = '0;
            state_nxt = S_PSTEP;
          end
          OP_FREE: begin
            if (!slot_ok) begin
              res_nxt.status = 1'b1;
              state_nxt      = S_OUT;
            end else if (oslot_idx == top_r) begin
              occ_we    = 1'b1;
              occ_wa    = top_r;
              occ_wd    = 1'b0;
              top_nxt   = top_low;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_FWR1;
            end
          end
          OP_REBIND: begin
            if (!slot_ok) begin
              res_nxt.status = 1'b1;
            end else begin
              own_we = 1'b1;
              occ_we = 1'b1;
              occ_wd = 1'b1;
            end
            state_nxt = S_OUT;
          end
          default: begin
            if (slot_in_range) begin
              state_nxt = S_LKUP;
            end else begin
              res_nxt.status = 1'b1;
              state_nxt      = S_OUT;
            end
          end
        endcase
      end
      S_PSTEP: begin
        p_nxt   = pn;
        n_nxt   = n_r + 1'b1;
        asid_ra = pn;
        if (pn != '0) begin
          state_nxt = S_PCHK;
        end else if (n_nxt == NW'(SLOT_COUNT)) begin
          state_nxt = S_TAKERD;
        end
      end
      S_PCHK: begin
        if (found || (n_r == NW'(SLOT_COUNT))) begin
          state_nxt = S_TAKERD;
        end else begin
          state_nxt = S_PSTEP;
        end
      end
      S_TAKERD: begin
        p_nxt     = pf;
        asid_ra   = pf;
        own_ra    = pf;
        state_nxt = S_TAKE;
      end
      S_TAKE: begin
        res_nxt.slot       = SLOT_FW'(p_r);
        res_nxt.asid       = asid_a;
        res_nxt.invalidate = 1'b1;
        if (occ_r[p_r]) begin
          res_nxt.evicted_valid = 1'b1;
          res_nxt.evicted_owner = own_rd_ext[OWNER_FW-1:0];
        end
        own_we    = 1'b1;
        own_wa    = p_r;
        own_wd    = owner_r;
        occ_we    = 1'b1;
        occ_wa    = p_r;
        occ_wd    = 1'b1;
        top_nxt   = p_r;
        state_nxt = S_OUT;
      end
      S_FWR1: begin
        if (occ_r[top_r]) begin
          res_nxt.moved_valid = 1'b1;
          res_nxt.moved_owner = own_rd_ext[OWNER_FW-1:0];
          res_nxt.moved_slot  = oslot_r;
        end
        own_we    = 1'b1;
        own_wd    = own_rd;
        occ_we    = 1'b1;
        occ_wd    = occ_r[top_r];
        asid_we   = 1'b1;
        asid_wd   = asid_b;
        swap_nxt  = asid_a;
        state_nxt = S_FWR2;
      end
      S_FWR2: begin
        asid_we   = 1'b1;
        asid_wa   = top_r;
        asid_wd   = swap_r;
        occ_we    = 1'b1;
        occ_wa    = top_r;
        occ_wd    = 1'b0;
        top_nxt   = top_low;
        state_nxt = S_OUT;
      end
      S_LKUP: begin
        res_nxt.slot = oslot_r;
        res_nxt.asid = asid_a;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      top_r   <= top_nxt;
      if (occ_we) begin
        occ_r[occ_wa] <= occ_wd;
      end
      if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_tvalid) begin
      op_r    <= in_tuser;
      owner_r <= owner_ext[OWNER_BITS-1:0];
      oslot_r <= in_tdata[23:16];
      cur_r   <= in_tdata[31:24];
    end
    if ((state_r == S_OUT) && (!out_valid_r || out_tready)) begin
      out_r <= res_r;
    end
    p_r    <= p_nxt;
    n_r    <= n_nxt;
    swap_r <= swap_nxt;
    res_r  <= res_nxt;
  end

  asa_asid_ram #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_asid (
    .clk     (clk),
    .rst_n   (rst_n),
    .ra_addr (asid_ra),
    .rb_addr (asid_rb),
    .we      (asid_we),
    .wa      (asid_wa),
    .wd      (asid_wd),
    .ra_data (asid_a),
    .rb_data (asid_b)
  );

  asa_owner_ram #(
    .SLOT_COUNT(SLOT_COUNT),
    .OWNER_BITS(OWNER_BITS)
  ) u_owner (
    .clk (clk),
    .ra  (own_ra),
    .we  (own_we),
    .wa  (own_wa),
    .wd  (own_wd),
    .rd  (own_rd)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {5'b0, out_r.moved_slot, out_r.moved_owner, out_r.moved_valid,
                       out_r.evicted_owner, out_r.evicted_valid, out_r.invalidate,
                       out_r.asid, out_r.slot};

endmodule

// ===== hw/rtl/asa_checker.sv =====
// asa_checker: port-level assertions for asid_slot_allocator, bound to the top level.
// Uses asa_pkg for output bit positions.
module asa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tuser
);
  import asa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while one is in flight");

  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 64'd0)
    else $error("rejected request carries data");

  a_alloc_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_INV_BIT] |->
      (out_tdata[7:0] != 8'd0) && !out_tdata[OUT_MVV_BIT])
    else $error("alloc result with slot 0 or a move");

  a_evict_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_EVV_BIT] |-> out_tdata[OUT_INV_BIT])
    else $error("eviction outside alloc");

endmodule

bind asid_slot_allocator asa_checker u_asa_checker (.*);
